@@ design/hcb_pkg.sv @@
// ----------------------------------------------------------------------------
// hcb_pkg
// shared constants and cell control types for the code table builder
// ----------------------------------------------------------------------------
`default_nettype none

package hcb_pkg;

    localparam int MAX_WORD_DEF = 4096;
    localparam int ALPHABET_DEF = 26;
    localparam int ID_W         = 6;
    localparam int LEN_W        = 5;
    localparam int MAX_CODE     = 25;
    localparam int SYM_W        = 5;

    // control broadcast to every cell of both chains
    typedef struct packed {
        logic             inc;
        logic [SYM_W-1:0] letter;
        logic             load;
        logic             shift;
        logic             merge;
        logic [ID_W-1:0]  id_a;
        logic [ID_W-1:0]  id_b;
        logic [ID_W-1:0]  id_next;
    } t_cell_ctl;

    typedef struct packed {
        logic            alive;
        logic [ID_W-1:0] id;
    } t_node_tag;

endpackage

`default_nettype wire

@@ design/hcb_stream_if.sv @@
// ----------------------------------------------------------------------------
// hcb stream interfaces
// letter input channel and code table output channel
// ----------------------------------------------------------------------------
`default_nettype none

interface hcb_in_if;
    logic       valid;
    logic       ready;
    logic [4:0] letter;
    logic       last;
    modport source (output valid, output letter, output last, input ready);
    modport sink   (input valid, input letter, input last, output ready);
endinterface

interface hcb_out_if;
    logic        valid;
    logic        ready;
    logic [4:0]  symbol;
    logic        present;
    logic [4:0]  code_length;
    logic [24:0] code_bits;
    logic        end_of_table;
    modport source (output valid, output symbol, output present, output code_length,
                    output code_bits, output end_of_table, input ready);
    modport sink   (input valid, input symbol, input present, input code_length,
                    input code_bits, input end_of_table, output ready);
endinterface

`default_nettype wire

@@ design/hcb_letter_cell.sv @@
// ----------------------------------------------------------------------------
// hcb_letter_cell
// one letter: occurrence count, current tree node and the code grown so far
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_letter_cell
    import hcb_pkg::*;
#(
    parameter int MAX_WORD = MAX_WORD_DEF,
    parameter int SLOT     = 0,
    localparam int CW      = $clog2(MAX_WORD + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cell_ctl        i_ctl,
    input  wire logic [CW-1:0]    i_nb_count,
    input  wire logic [LEN_W-1:0] i_nb_len,
    input  wire logic [24:0]      i_nb_bits,
    output logic [CW-1:0]         o_count,
    output logic [LEN_W-1:0]      o_len,
    output logic [24:0]           o_bits
);

    localparam logic [SYM_W-1:0] MY_SYM = SYM_W'(SLOT);
    localparam logic [CW-1:0]    CMAX   = CW'(MAX_WORD);

    logic [CW-1:0]    r_count;
    logic [LEN_W-1:0] r_len;
    logic [24:0]      r_bits;
    logic [ID_W-1:0]  r_node;
    logic             w_hit;

    assign w_hit = (r_node == i_ctl.id_a) || (r_node == i_ctl.id_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.shift) begin
            r_count <= i_nb_count;
        end else if (i_ctl.inc && i_ctl.letter == MY_SYM && r_count < CMAX) begin
            r_count <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_len  <= i_nb_len;
            r_bits <= i_nb_bits;
        end else if (i_ctl.load) begin
            r_len  <= '0;
            r_bits <= '0;
            r_node <= ID_W'(SLOT);
        end else if (i_ctl.merge && w_hit) begin
            r_node <= i_ctl.id_next;
            if (r_len < LEN_W'(MAX_CODE)) begin
                // second node taken is the 1 branch
                if (r_node == i_ctl.id_b)
                    r_bits <= r_bits | (25'(1) << r_len);
                r_len <= r_len + LEN_W'(1);
            end
        end
    end

    assign o_count = r_count;
    assign o_len   = r_len;
    assign o_bits  = r_bits;

endmodule

`default_nettype wire

@@ design/hcb_node_cell.sv @@
// ----------------------------------------------------------------------------
// hcb_node_cell
// one slot of the node ring: weight, node id and queue membership
// ----------------------------------------------------------------------------
`default_nettype none

module hcb_node_cell
    import hcb_pkg::*;
#(
    parameter int WW   = 17,
    parameter int SLOT = 0
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_cell_ctl     i_ctl,
    input  wire logic          i_load_alive,
    input  wire logic [WW-1:0] i_load_weight,
    input  wire logic [WW-1:0] i_sum,
    input  wire t_node_tag     i_nb_tag,
    input  wire logic [WW-1:0] i_nb_weight,
    output t_node_tag          o_tag,
    output logic [WW-1:0]      o_weight
);

    logic            r_alive;
    logic [ID_W-1:0] r_id;
    logic [WW-1:0]   r_weight;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alive <= 1'b0;
        end else if (i_ctl.shift) begin
            r_alive <= i_nb_tag.alive;
        end else if (i_ctl.load) begin
            r_alive <= i_load_alive;
        end else if (i_ctl.merge) begin
            if (r_id == i_ctl.id_next)
                r_alive <= 1'b1;
            else if (r_id == i_ctl.id_a || r_id == i_ctl.id_b)
                r_alive <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift) begin
            r_id     <= i_nb_tag.id;
            r_weight <= i_nb_weight;
        end else if (i_ctl.load) begin
            r_id     <= ID_W'(SLOT);
            r_weight <= i_load_weight;
        end else if (i_ctl.merge && r_id == i_ctl.id_next) begin
            r_weight <= i_sum;
        end
    end

    assign o_tag    = {r_alive, r_id};
    assign o_weight = r_weight;

endmodule

`default_nettype wire

@@ design/huffman_code_builder.sv @@
// ----------------------------------------------------------------------------
// huffman_code_builder
// counts the letters of a word and emits a Huffman code table for it
// ----------------------------------------------------------------------------
// Usage: letters arrive on i_in, one per beat, one beat per cycle while
// ready is high. The beat with last set closes the word; ready then drops
// while the code is built. The build loads a ring of 2*ALPHABET-1 node
// cells, then repeats a scan that rotates the ring once, picking the two
// least live nodes, each scan followed by a merge step. With k distinct
// letters that is k-1 merges plus a final scan. The table then leaves
// on o_out as ALPHABET beats in letter order, taken from the head of
// the letter cell chain, which shifts one place per beat and is zero
// again after the last one. A stall on o_out holds the head beat.
// Counting resumes after the beat with end_of_table.
// Reset clears all counts and returns to accepting letters.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_builder
    import hcb_pkg::*;
#(
    parameter int MAX_WORD = MAX_WORD_DEF,
    parameter int ALPHABET = ALPHABET_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hcb_in_if.sink     i_in,
    hcb_out_if.source  o_out
);

    localparam int ND = 2 * ALPHABET - 1;
    localparam int CW = $clog2(MAX_WORD + 1);
    localparam int WW = $clog2(MAX_WORD * ALPHABET + 1);
    localparam logic [ID_W-1:0]  ND_ID   = ID_W'(ND);
    localparam logic [ID_W-1:0]  LAST_ID = ID_W'(ND - 1);
    localparam logic [ID_W-1:0]  ALPH_ID = ID_W'(ALPHABET);
    localparam logic [SYM_W-1:0] LAST_SYM = SYM_W'(ALPHABET - 1);

    typedef enum logic [2:0] {S_COUNT, S_LOAD, S_SCAN, S_MERGE, S_EMIT} t_state;

    t_state          r_state;
    logic [ID_W-1:0] r_cnt;
    logic [ID_W-1:0] r_fill;
    logic [ID_W-1:0] r_next;
    logic [SYM_W-1:0] r_sym;
    logic [WW-1:0]   r_w1, r_w2;
    logic [ID_W-1:0] r_id1, r_id2;

    t_cell_ctl w_ctl;
    logic      w_in_acc, w_out_acc;

    logic [CW-1:0]    w_count [ALPHABET];
    logic [LEN_W-1:0] w_len   [ALPHABET];
    logic [24:0]      w_bits  [ALPHABET];
    t_node_tag        w_tag   [ND];
    logic [WW-1:0]    w_wt    [ND];

    // ordering: weight, then letters before merged nodes, then id
    function automatic logic node_less(input logic [WW-1:0] wa, input logic [ID_W-1:0] ia,
                                       input logic [WW-1:0] wb, input logic [ID_W-1:0] ib);
        logic la, lb;
        la = ia < ALPH_ID;
        lb = ib < ALPH_ID;
        if (wa != wb) return wa < wb;
        if (la != lb) return la;
        return ia < ib;
    endfunction

    assign w_in_acc  = i_in.valid && i_in.ready;
    assign w_out_acc = o_out.valid && o_out.ready;

    always_comb begin
        w_ctl         = '0;
        w_ctl.inc     = w_in_acc;
        w_ctl.letter  = i_in.letter;
        w_ctl.load    = (r_state == S_LOAD);
        w_ctl.id_a    = r_id1;
        w_ctl.id_b    = r_id2;
        w_ctl.id_next = r_next;
        w_ctl.merge   = (r_state == S_MERGE) && (r_fill >= ID_W'(2)) && (r_next < ND_ID);
    end

    // letter chain shifts only on output beats, node ring only while scanning
    t_cell_ctl w_lctl, w_nctl;
    always_comb begin
        w_lctl       = w_ctl;
        w_lctl.shift = w_out_acc;
        w_nctl       = w_ctl;
        w_nctl.shift = (r_state == S_SCAN);
    end

    for (genvar k = 0; k < ALPHABET; k++) begin : g_letter
        logic [CW-1:0]    w_nc;
        logic [LEN_W-1:0] w_nl;
        logic [24:0]      w_nb;
        if (k == ALPHABET - 1) begin : g_tail
            assign w_nc = '0;
            assign w_nl = '0;
            assign w_nb = '0;
        end else begin : g_mid
            assign w_nc = w_count[k+1];
            assign w_nl = w_len[k+1];
            assign w_nb = w_bits[k+1];
        end
        hcb_letter_cell #(.MAX_WORD(MAX_WORD), .SLOT(k)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_lctl),
            .i_nb_count (w_nc),
            .i_nb_len   (w_nl),
            .i_nb_bits  (w_nb),
            .o_count    (w_count[k]),
            .o_len      (w_len[k]),
            .o_bits     (w_bits[k])
        );
    end

    for (genvar k = 0; k < ND; k++) begin : g_node
        logic          w_la;
        logic [WW-1:0] w_lw;
        if (k < ALPHABET) begin : g_leaf
            assign w_la = (w_count[k] != '0);
            assign w_lw = WW'(w_count[k]);
        end else begin : g_inner
            assign w_la = 1'b0;
            assign w_lw = '0;
        end
        hcb_node_cell #(.WW(WW), .SLOT(k)) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (w_nctl),
            .i_load_alive  (w_la),
            .i_load_weight (w_lw),
            .i_sum         (r_w1 + r_w2),
            .i_nb_tag      (w_tag[(k + 1) % ND]),
            .i_nb_weight   (w_wt[(k + 1) % ND]),
            .o_tag         (w_tag[k]),
            .o_weight      (w_wt[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COUNT;
            r_cnt   <= '0;
            r_fill  <= '0;
            r_next  <= '0;
            r_sym   <= '0;
        end else begin
            unique case (r_state)
                S_COUNT: begin
                    if (w_in_acc && i_in.last)
                        r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_next  <= ALPH_ID;
                    r_cnt   <= '0;
                    r_fill  <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    // head cell is examined before the ring moves on
                    if (w_tag[0].alive) begin
                        r_fill <= r_fill + ID_W'(1);
                        if (r_fill == '0 ||
                            node_less(w_wt[0], w_tag[0].id, r_w1, r_id1)) begin
                            r_w1  <= w_wt[0];
                            r_id1 <= w_tag[0].id;
                            r_w2  <= r_w1;
                            r_id2 <= r_id1;
                        end else if (r_fill == ID_W'(1) ||
                                     node_less(w_wt[0], w_tag[0].id, r_w2, r_id2)) begin
                            r_w2  <= w_wt[0];
                            r_id2 <= w_tag[0].id;
                        end
                    end
                    if (r_cnt == LAST_ID) begin
                        r_cnt   <= '0;
                        r_state <= S_MERGE;
                    end else begin
                        r_cnt <= r_cnt + ID_W'(1);
                    end
                end
                S_MERGE: begin
                    r_fill <= '0;
                    r_sym  <= '0;
                    if (w_ctl.merge) begin
                        r_next  <= r_next + ID_W'(1);
                        r_state <= S_SCAN;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_out_acc) begin
                        r_sym <= r_sym + SYM_W'(1);
                        if (r_sym == LAST_SYM)
                            r_state <= S_COUNT;
                    end
                end
                default: r_state <= S_COUNT;
            endcase
        end
    end

    assign i_in.ready         = (r_state == S_COUNT);
    assign o_out.valid        = (r_state == S_EMIT);
    assign o_out.symbol       = r_sym;
    assign o_out.present      = (w_count[0] != '0);
    assign o_out.code_length  = w_len[0];
    assign o_out.code_bits    = w_bits[0];
    assign o_out.end_of_table = (r_sym == LAST_SYM);

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid))
        else $error("input and output open together");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= ALPH_ID)
        else $error("live node count exceeds alphabet");

    a_next_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MERGE |-> r_next <= ND_ID)
        else $error("node id beyond ring");

    a_table_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && o_out.end_of_table |=> r_state == S_COUNT && w_count[0] == '0)
        else $error("counts not cleared after table");

    a_last_builds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_in.last |=> r_state == S_LOAD)
        else $error("last beat did not start a build");

endmodule

`default_nettype wire
